// ----- rtl/knn_pkg.sv -----
// Shared types and constants of the nearest-neighbour search block.
package knn_pkg;

   // Field widths of the request, result and register interfaces.
   localparam int REQ_POINT_BITS  = 10;
   localparam int REQ_DIM_BITS    = 4;
   localparam int REQ_SAMPLE_BITS = 16;
   localparam int RSP_INDEX_BITS  = 11;
   localparam int RSP_RANK_BITS   = 3;

   localparam int CFG_K_BITS      = 4;
   localparam int CFG_RADIUS_BITS = 10;
   localparam int CFG_DIMS_BITS   = 5;
   localparam int CFG_POINTS_BITS = 11;

   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEIGHBOURS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXCLUSION  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIMS       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POINTS     = 3'd3;

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Squared distances saturate at all ones in this many bits.
   localparam int DIST_BITS = 38;
   localparam logic [DIST_BITS-1:0] DIST_ALL_ONES = '1;

   typedef struct packed {
      logic                              req_type;
      logic [REQ_POINT_BITS-1:0]         point_index;
      logic [REQ_DIM_BITS-1:0]           dim_index;
      logic signed [REQ_SAMPLE_BITS-1:0] sample_value;
   } knn_req_type;

   typedef struct packed {
      logic [RSP_INDEX_BITS-1:0] neighbour_index;
      logic [RSP_RANK_BITS-1:0]  rank;
      logic                      last;
   } knn_rsp_type;

   // Commands that drive every cell of the sorted list at once.
   typedef struct packed {
      logic clear;
      logic insert;
      logic shift_out;
   } knn_cell_ctl_type;

   // Tag that travels with one coordinate through the distance pipeline.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } knn_tag_type;

endpackage

// ----- rtl/knn_search_with_exclusion.sv -----
// Top level of the brute-force nearest-neighbour search with index exclusion.
// A load transfer writes one coordinate to the store; the block is ready again next cycle.
// A query scans each configured point coordinate by coordinate, skipping excluded points,
// drains the distance pipeline, then reports the neighbours in rank order; requests stall meanwhile.
// The rate is set by the single shared multiply-accumulate and the two store read ports.
// Synchronous reset restores register defaults and idles the block; the point store is kept.
module knn_search_with_exclusion #(
   parameter int MAX_POINTS     = 1024,
   parameter int MAX_DIMS       = 16,
   parameter int MAX_NEIGHBOURS = 8,
   parameter int SAMPLE_BITS    = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  knn_pkg::knn_req_type                   req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output knn_pkg::knn_rsp_type                   rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [knn_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [knn_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import knn_pkg::*;

   localparam int PW    = $clog2(MAX_POINTS);
   localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int KW    = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
   localparam int QW    = (PW > REQ_POINT_BITS) ? PW : REQ_POINT_BITS;
   localparam int DEPTH = MAX_POINTS * MAX_DIMS;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = ((PW > RSP_INDEX_BITS) ? PW : RSP_INDEX_BITS) + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   // Control state.
   logic [1:0]                 state_ff, state_in;
   logic [PW-1:0]              j_ff, j_in;
   logic [DW-1:0]              d_ff, d_in;
   logic [KW-1:0]              s_ff, s_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   knn_tag_type                s1_tag_ff, s1_tag_in;

   // Configuration registers.
   logic [CFG_K_BITS-1:0]      k_raw_ff, k_raw_in;
   logic [CFG_RADIUS_BITS-1:0] radius_ff, radius_in;
   logic [CFG_DIMS_BITS-1:0]   dims_raw_ff, dims_raw_in;
   logic [CFG_POINTS_BITS-1:0] points_raw_ff, points_raw_in;

   // Per-query settings captured when the query is taken.
   logic [QW-1:0]              q_ff;
   logic [PW-1:0]              q_pt_ff;
   logic                       q_ok_ff;
   logic [KW-1:0]              last_k_ff, last_k_calc;
   logic [DW-1:0]              last_d_ff, last_d_calc;
   logic [PW-1:0]              last_j_ff, last_j_calc;

   // Point store and its read path.
   logic [SAMPLE_BITS-1:0]     store_mem [DEPTH];
   logic [SAMPLE_BITS-1:0]     q_sample_ff, j_sample_ff;
   logic [PW-1:0]              s1_point_ff;
   logic [AW-1:0]              wr_addr, q_addr, j_addr;
   logic [SAMPLE_BITS+REQ_SAMPLE_BITS-1:0] wr_wide;
   logic                       load_write;

   logic                       req_accept, query_accept, load_accept;
   logic [QW-1:0]              j_ext, gap;
   logic                       excluded, issue, step_j, out_free, load_out;
   knn_rsp_type                rsp_data_ff, rsp_next;

   // Distance pipeline outputs.
   logic                       mac_busy, cand_valid;
   logic [DIST_BITS-1:0]       cand_dist;
   logic [PW-1:0]              cand_point;
   logic signed [SAMPLE_BITS-1:0] mac_a;

   // Sorted list cells.
   knn_cell_ctl_type           cell_ctl;
   logic                       cell_valid [MAX_NEIGHBOURS];
   logic [DIST_BITS-1:0]       cell_dist  [MAX_NEIGHBOURS];
   logic [PW-1:0]              cell_point [MAX_NEIGHBOURS];
   logic                       cell_stays [MAX_NEIGHBOURS];

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid & ~req_stall;
   assign query_accept = req_accept & (req_data.req_type == REQ_QUERY);
   assign load_accept  = req_accept & (req_data.req_type == REQ_LOAD);
   assign csr_ready    = 1'b1;

   // Register writes; indexes past the list are dropped.
   always_comb begin
      k_raw_in      = k_raw_ff;
      radius_in     = radius_ff;
      dims_raw_in   = dims_raw_ff;
      points_raw_in = points_raw_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NEIGHBOURS: k_raw_in      = csr_wdata[CFG_K_BITS-1:0];
            CSR_EXCLUSION:  radius_in     = csr_wdata[CFG_RADIUS_BITS-1:0];
            CSR_DIMS:       dims_raw_in   = csr_wdata[CFG_DIMS_BITS-1:0];
            CSR_POINTS:     points_raw_in = csr_wdata[CFG_POINTS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Register values saturate into their legal ranges; kept as last index.
   assign last_k_calc = (k_raw_ff == '0) ? '0 :
                        (32'(k_raw_ff) > 32'(MAX_NEIGHBOURS)) ? KW'(MAX_NEIGHBOURS - 1) :
                        KW'(k_raw_ff - 1'b1);
   assign last_d_calc = (dims_raw_ff == '0) ? '0 :
                        (32'(dims_raw_ff) > 32'(MAX_DIMS)) ? DW'(MAX_DIMS - 1) :
                        DW'(dims_raw_ff - 1'b1);
   assign last_j_calc = (points_raw_ff == '0) ? '0 :
                        (32'(points_raw_ff) > 32'(MAX_POINTS)) ? PW'(MAX_POINTS - 1) :
                        PW'(points_raw_ff - 1'b1);

   // Points within the exclusion radius of the query index are skipped.
   assign j_ext    = QW'(j_ff);
   assign gap      = (j_ext > q_ff) ? (j_ext - q_ff) : (q_ff - j_ext);
   assign excluded = (32'(gap) <= 32'(radius_ff));
   assign issue    = (state_ff == ST_SCAN) && !excluded;
   assign step_j   = (state_ff == ST_SCAN) && (excluded || (d_ff == last_d_ff));

   // Results leave through a single output register.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == ST_EMIT) && out_free;

   // Sequencer: scan points and coordinates, drain, then emit the list.
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      d_in         = d_ff;
      s_in         = s_ff;
      rsp_valid_in = out_free ? load_out : rsp_valid_ff;
      s1_tag_in.valid = issue;
      s1_tag_in.first = (d_ff == '0);
      s1_tag_in.last  = (d_ff == last_d_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (query_accept) begin
               state_in = ST_SCAN;
               j_in     = '0;
               d_in     = '0;
            end
         end
         ST_SCAN: begin
            if (step_j) begin
               d_in = '0;
               if (j_ff == last_j_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               d_in = d_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!s1_tag_ff.valid && !mac_busy) begin
               state_in = ST_EMIT;
               s_in     = '0;
            end
         end
         ST_EMIT: begin
            if (load_out) begin
               s_in = s_ff + 1'b1;
               if (s_ff == last_k_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         j_ff          <= '0;
         d_ff          <= '0;
         s_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
         s1_tag_ff     <= '0;
         k_raw_ff      <= CFG_K_BITS'(1);
         radius_ff     <= '0;
         dims_raw_ff   <= CFG_DIMS_BITS'(1);
         points_raw_ff <= CFG_POINTS_BITS'(1);
      end else begin
         state_ff      <= state_in;
         j_ff          <= j_in;
         d_ff          <= d_in;
         s_ff          <= s_in;
         rsp_valid_ff  <= rsp_valid_in;
         s1_tag_ff     <= s1_tag_in;
         k_raw_ff      <= k_raw_in;
         radius_ff     <= radius_in;
         dims_raw_ff   <= dims_raw_in;
         points_raw_ff <= points_raw_in;
      end
   end

   // Query settings are captured on the query transfer.
   always_ff @(posedge clock) begin
      if (query_accept) begin
         q_ff      <= QW'(req_data.point_index);
         q_ok_ff   <= (32'(req_data.point_index) < 32'(MAX_POINTS));
         q_pt_ff   <= (32'(req_data.point_index) < 32'(MAX_POINTS)) ?
                      PW'(req_data.point_index) : '0;
         last_k_ff <= last_k_calc;
         last_d_ff <= last_d_calc;
         last_j_ff <= last_j_calc;
      end
   end

   // Point store: one write port for loads, two read ports for the scan.
   assign load_write = load_accept &&
                       (32'(req_data.point_index) < 32'(MAX_POINTS)) &&
                       (32'(req_data.dim_index) < 32'(MAX_DIMS));
   assign wr_wide = {{SAMPLE_BITS{1'b0}}, req_data.sample_value};
   assign wr_addr = AW'(PW'(req_data.point_index)) * AW'(MAX_DIMS) +
                    AW'(DW'(req_data.dim_index));
   assign q_addr  = AW'(q_pt_ff) * AW'(MAX_DIMS) + AW'(d_ff);
   assign j_addr  = AW'(j_ff) * AW'(MAX_DIMS) + AW'(d_ff);

   always_ff @(posedge clock) begin
      if (load_write) begin
         store_mem[wr_addr] <= wr_wide[SAMPLE_BITS-1:0];
      end
      q_sample_ff <= store_mem[q_addr];
      j_sample_ff <= store_mem[j_addr];
      s1_point_ff <= j_ff;
   end

   // A query index beyond the store compares against all-zero coordinates.
   assign mac_a = q_ok_ff ? $signed(q_sample_ff) : '0;

   knn_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .POINT_BITS  (PW)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .in_tag     (s1_tag_ff),
      .in_point   (s1_point_ff),
      .in_a       (mac_a),
      .in_b       ($signed(j_sample_ff)),
      .busy       (mac_busy),
      .cand_valid (cand_valid),
      .cand_dist  (cand_dist),
      .cand_point (cand_point)
   );

   // Sorted list: cleared when a query is taken, inserts each candidate, shifts toward slot zero on output.
   assign cell_ctl.clear     = query_accept;
   assign cell_ctl.insert    = cand_valid;
   assign cell_ctl.shift_out = load_out;

   for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
      logic                 p_stays, p_valid, n_valid;
      logic [DIST_BITS-1:0] p_dist, n_dist;
      logic [PW-1:0]        p_point, n_point;

      if (i == 0) begin : g_head
         assign p_stays = 1'b1;
         assign p_valid = 1'b0;
         assign p_dist  = '0;
         assign p_point = '0;
      end else begin : g_prev
         assign p_stays = cell_stays[i-1];
         assign p_valid = cell_valid[i-1];
         assign p_dist  = cell_dist[i-1];
         assign p_point = cell_point[i-1];
      end

      if (i == MAX_NEIGHBOURS - 1) begin : g_tail
         assign n_valid = 1'b0;
         assign n_dist  = '0;
         assign n_point = '0;
      end else begin : g_next
         assign n_valid = cell_valid[i+1];
         assign n_dist  = cell_dist[i+1];
         assign n_point = cell_point[i+1];
      end

      knn_cell #(
         .POINT_BITS (PW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .is_last    (last_k_ff == KW'(i)),
         .cand_dist  (cand_dist),
         .cand_point (cand_point),
         .prev_stays (p_stays),
         .prev_valid (p_valid),
         .prev_dist  (p_dist),
         .prev_point (p_point),
         .next_valid (n_valid),
         .next_dist  (n_dist),
         .next_point (n_point),
         .valid      (cell_valid[i]),
         .slot_dist  (cell_dist[i]),
         .point      (cell_point[i]),
         .stays      (cell_stays[i])
      );
   end

   // Result from slot zero; an unfilled slot reports point zero.
   assign rsp_next.neighbour_index = cell_valid[0] ?
                                     RSP_INDEX_BITS'(XW'(cell_point[0]) + XW'(1)) :
                                     RSP_INDEX_BITS'(1);
   assign rsp_next.rank = RSP_RANK_BITS'(s_ff);
   assign rsp_next.last = (s_ff == last_k_ff);

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/knn_mac.sv -----
// Pipelined squared-difference accumulator that yields one distance per scanned point.
module knn_mac #(
   parameter int SAMPLE_BITS = 16,
   parameter int POINT_BITS  = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  knn_pkg::knn_tag_type              in_tag,
   input  logic [POINT_BITS-1:0]             in_point,
   input  logic signed [SAMPLE_BITS-1:0]     in_a,
   input  logic signed [SAMPLE_BITS-1:0]     in_b,
   output logic                              busy,
   output logic                              cand_valid,
   output logic [knn_pkg::DIST_BITS-1:0]     cand_dist,
   output logic [POINT_BITS-1:0]             cand_point
);
   import knn_pkg::*;

   localparam int SQ_BITS  = 2 * SAMPLE_BITS;
   localparam int SUM_BITS = ((SQ_BITS > DIST_BITS) ? SQ_BITS : DIST_BITS) + 1;

   knn_tag_type            mag_tag_ff, sq_tag_ff;
   logic [POINT_BITS-1:0]  mag_point_ff, sq_point_ff, cand_point_ff;
   logic [SAMPLE_BITS-1:0] mag_ff, mag_in;
   logic [SQ_BITS-1:0]     sq_ff, sq_in;
   logic [DIST_BITS-1:0]   acc_ff, acc_in, acc_base;
   logic [DIST_BITS-1:0]   cand_dist_ff;
   logic                   cand_valid_ff;
   logic signed [SAMPLE_BITS:0] diff;
   logic [SUM_BITS-1:0]    sum;

   // Magnitude of the coordinate difference; it always fits the sample width.
   assign diff   = $signed({in_a[SAMPLE_BITS-1], in_a}) - $signed({in_b[SAMPLE_BITS-1], in_b});
   assign mag_in = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];

   // Square of the magnitude.
   assign sq_in = SQ_BITS'(mag_ff) * SQ_BITS'(mag_ff);

   // Saturating accumulation, restarted on the first coordinate of a point.
   assign acc_base = sq_tag_ff.first ? '0 : acc_ff;
   assign sum      = SUM_BITS'(acc_base) + SUM_BITS'(sq_ff);
   assign acc_in   = (sum >= SUM_BITS'(DIST_ALL_ONES)) ? DIST_ALL_ONES : DIST_BITS'(sum);

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_tag_ff    <= '0;
         sq_tag_ff     <= '0;
         cand_valid_ff <= 1'b0;
      end else begin
         mag_tag_ff    <= in_tag;
         sq_tag_ff     <= mag_tag_ff;
         cand_valid_ff <= sq_tag_ff.valid & sq_tag_ff.last;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      mag_point_ff <= in_point;
      sq_ff        <= sq_in;
      sq_point_ff  <= mag_point_ff;
      if (sq_tag_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (sq_tag_ff.valid && sq_tag_ff.last) begin
         cand_dist_ff  <= acc_in;
         cand_point_ff <= sq_point_ff;
      end
   end

   assign busy       = mag_tag_ff.valid | sq_tag_ff.valid | cand_valid_ff;
   assign cand_valid = cand_valid_ff;
   assign cand_dist  = cand_dist_ff;
   assign cand_point = cand_point_ff;

endmodule

// ----- rtl/knn_cell.sv -----
// One slot of the sorted neighbour list, linked to the slots on either side.
module knn_cell #(
   parameter int POINT_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  knn_pkg::knn_cell_ctl_type     ctl,
   input  logic                          is_last,
   input  logic [knn_pkg::DIST_BITS-1:0] cand_dist,
   input  logic [POINT_BITS-1:0]         cand_point,
   input  logic                          prev_stays,
   input  logic                          prev_valid,
   input  logic [knn_pkg::DIST_BITS-1:0] prev_dist,
   input  logic [POINT_BITS-1:0]         prev_point,
   input  logic                          next_valid,
   input  logic [knn_pkg::DIST_BITS-1:0] next_dist,
   input  logic [POINT_BITS-1:0]         next_point,
   output logic                          valid,
   output logic [knn_pkg::DIST_BITS-1:0] slot_dist,
   output logic [POINT_BITS-1:0]         point,
   output logic                          stays
);
   import knn_pkg::*;

   logic                  valid_ff, valid_in;
   logic [DIST_BITS-1:0]  dist_ff, dist_in;
   logic [POINT_BITS-1:0] point_ff, point_in;
   logic                  keep;

   // An entry stays ahead of a candidate of equal or larger distance. The last
   // slot of the list gives way to a tie, so an equal newer point replaces it.
   assign stays = valid_ff && (dist_ff <= cand_dist);
   assign keep  = is_last ? (valid_ff && (dist_ff < cand_dist)) : stays;

   // Next slot content: clear, shift toward the head, or insertion step.
   always_comb begin
      valid_in = valid_ff;
      dist_in  = dist_ff;
      point_in = point_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift_out) begin
         valid_in = next_valid;
         dist_in  = next_dist;
         point_in = next_point;
      end else if (ctl.insert && !keep) begin
         if (prev_stays) begin
            valid_in = 1'b1;
            dist_in  = cand_dist;
            point_in = cand_point;
         end else begin
            valid_in = prev_valid;
            dist_in  = prev_dist;
            point_in = prev_point;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff  <= dist_in;
      point_ff <= point_in;
   end

   assign valid     = valid_ff;
   assign slot_dist = dist_ff;
   assign point     = point_ff;

endmodule

// ----- rtl/knn_checker.sv -----
// Port-level checks of the nearest-neighbour search block and their binding.
module knn_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input knn_pkg::knn_req_type               req_data,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input knn_pkg::knn_rsp_type               rsp_data
);
   import knn_pkg::*;

   // A stalled result holds its value until the transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A query transfer makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.req_type == REQ_QUERY) |=> req_stall)
      else $error("block took a request right after a query");

   // While a result other than the final one waits, no request is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("request taken while a query still reports results");

   // The rank after a non-final transfer counts up by one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last ##1 rsp_valid |->
         rsp_data.rank == $past(rsp_data.rank) + 3'd1)
      else $error("rank did not advance");

endmodule

bind knn_search_with_exclusion knn_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- sim/knn_search_with_exclusion_test.sv -----
// Self-checking testbench of the nearest-neighbour search block with index exclusion.
module knn_search_with_exclusion_test;
   timeunit 1ns;
   timeprecision 1ps;

   import knn_pkg::*;

   localparam int MAX_POINTS     = 1024;
   localparam int MAX_DIMS       = 16;
   localparam int MAX_NEIGHBOURS = 8;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 600;

   typedef logic [DIST_BITS-1:0] distance_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   knn_req_type               req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   knn_rsp_type               rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Predicted coordinates and which of them have been loaded so far.
   logic signed [REQ_SAMPLE_BITS-1:0] coord_store [MAX_POINTS][MAX_DIMS];
   bit                                loaded_mask [MAX_POINTS][MAX_DIMS];

   // Predicted register contents.
   logic [CFG_K_BITS-1:0]      neighbours_cfg = 1;
   logic [CFG_RADIUS_BITS-1:0] exclusion_cfg  = 0;
   logic [CFG_DIMS_BITS-1:0]   dims_cfg       = 1;
   logic [CFG_POINTS_BITS-1:0] points_cfg     = 1;

   knn_rsp_type neighbour_queue [$];
   int          error_count   = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   logic        hold_on       = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   knn_search_with_exclusion uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t ns: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic int clamp_count(int raw, int hi);
      if (raw < 1) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   // Squared Euclidean distance between two stored points, saturating at all ones.
   function automatic distance_type squared_gap(int q, int j, int dims);
      longint acc;
      longint diff;
      acc = 0;
      for (int d = 0; d < dims; d++) begin
         diff = longint'(coord_store[q][d]) - longint'(coord_store[j][d]);
         if (diff < 0) diff = -diff;
         acc = acc + diff * diff;
         if (acc > longint'(DIST_ALL_ONES)) acc = longint'(DIST_ALL_ONES);
      end
      return distance_type'(acc);
   endfunction

   // Scan the configured points and queue the k nearest ones in nearest-first order.
   task automatic predict_neighbours(int q);
      distance_type best_d [MAX_NEIGHBOURS];
      int           best_p [MAX_NEIGHBOURS];
      distance_type cand_d;
      distance_type worst;
      knn_rsp_type  r;
      int           k;
      int           dims;
      int           npts;
      int           fill;
      int           gap;
      int           pos;
      k    = clamp_count(neighbours_cfg, MAX_NEIGHBOURS);
      dims = clamp_count(dims_cfg, MAX_DIMS);
      npts = clamp_count(points_cfg, MAX_POINTS);
      for (int s = 0; s < MAX_NEIGHBOURS; s++) begin
         best_d[s] = DIST_ALL_ONES;
         best_p[s] = 0;
      end
      worst = DIST_ALL_ONES;
      fill  = 0;
      for (int j = 0; j < npts; j++) begin
         gap = (j > q) ? j - q : q - j;
         if (gap > exclusion_cfg) begin
            cand_d = squared_gap(q, j, dims);
            if (fill < k || cand_d <= worst) begin
               // Equal distances keep the older point in front.
               pos = (fill < k) ? fill : k - 1;
               while (pos > 0 && best_d[pos-1] > cand_d) begin
                  best_d[pos] = best_d[pos-1];
                  best_p[pos] = best_p[pos-1];
                  pos--;
               end
               best_d[pos] = cand_d;
               best_p[pos] = j;
               if (fill < k) fill++;
               if (fill >= k) worst = best_d[k-1];
            end
         end
      end
      for (int s = 0; s < k; s++) begin
         r.neighbour_index = RSP_INDEX_BITS'(((s < fill) ? best_p[s] : 0) + 1);
         r.rank            = RSP_RANK_BITS'(s);
         r.last            = (s == k - 1);
         neighbour_queue.push_back(r);
      end
   endtask

   // Result checking and receiver stall, both on the rising edge.
   always @(posedge clock) begin
      knn_rsp_type expected_rsp;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (neighbour_queue.size() == 0) begin
            report_mismatch("unexpected result transfer, neighbour_index",
                            rsp_data.neighbour_index, 0);
         end else begin
            expected_rsp = neighbour_queue.pop_front();
            if (rsp_data.neighbour_index !== expected_rsp.neighbour_index)
               report_mismatch("neighbour_index", rsp_data.neighbour_index,
                               expected_rsp.neighbour_index);
            if (rsp_data.rank !== expected_rsp.rank)
               report_mismatch("rank", rsp_data.rank, expected_rsp.rank);
            if (rsp_data.last !== expected_rsp.last)
               report_mismatch("last", rsp_data.last, expected_rsp.last);
         end
      end
      rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);
   end

   task automatic set_idling(int sender_pct, int receiver_pct);
      send_idle_pct = sender_pct;
      stall_pct    <= receiver_pct;
   endtask

   // Offer one request, wait for its transfer and update the prediction.
   task automatic send_item(knn_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (item.req_type == REQ_LOAD) begin
         coord_store[item.point_index][item.dim_index] = item.sample_value;
         loaded_mask[item.point_index][item.dim_index] = 1'b1;
      end else begin
         predict_neighbours(item.point_index);
      end
   endtask

   task automatic load_coord(int p, int d, logic [REQ_SAMPLE_BITS-1:0] value);
      knn_req_type item;
      item.req_type     = REQ_LOAD;
      item.point_index  = REQ_POINT_BITS'(p);
      item.dim_index    = REQ_DIM_BITS'(d);
      item.sample_value = value;
      send_item(item);
   endtask

   // A query carries random junk in the fields it ignores.
   task automatic query_point(int p);
      knn_req_type item;
      item.req_type     = REQ_QUERY;
      item.point_index  = REQ_POINT_BITS'(p);
      item.dim_index    = REQ_DIM_BITS'($urandom_range(MAX_DIMS - 1));
      item.sample_value = REQ_SAMPLE_BITS'($urandom);
      send_item(item);
   endtask

   // Drop valid and wait until every predicted result has arrived and the block settles.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (neighbour_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; bits above the field width carry random junk half the time.
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, int value, int width);
      logic [CSR_DATA_BITS-1:0] data;
      data = CSR_DATA_BITS'(value);
      if (width < CSR_DATA_BITS && $urandom_range(1) == 1)
         data = data | (CSR_DATA_BITS'($urandom) << width);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_NEIGHBOURS: neighbours_cfg = data[CFG_K_BITS-1:0];
         CSR_EXCLUSION:  exclusion_cfg  = data[CFG_RADIUS_BITS-1:0];
         CSR_DIMS:       dims_cfg       = data[CFG_DIMS_BITS-1:0];
         CSR_POINTS:     points_cfg     = data[CFG_POINTS_BITS-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(int k, int radius, int dims, int npts);
      wait_idle();
      write_reg(CSR_NEIGHBOURS, k, CFG_K_BITS);
      write_reg(CSR_EXCLUSION, radius, CFG_RADIUS_BITS);
      write_reg(CSR_DIMS, dims, CFG_DIMS_BITS);
      write_reg(CSR_POINTS, npts, CFG_POINTS_BITS);
   endtask

   // Half of the values are small, so that equal distances are common.
   function automatic logic [REQ_SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(3))
         0:       return REQ_SAMPLE_BITS'($urandom);
         1:       return REQ_SAMPLE_BITS'($urandom_range(6)) - 16'd3;
         2:       return ($urandom_range(1) == 1) ? 16'h7FFF : 16'h8000;
         default: return REQ_SAMPLE_BITS'($urandom_range(7));
      endcase
   endfunction

   // Load every coordinate a query can read under the current registers.
   task automatic fill_active_set();
      int dims;
      int npts;
      dims = clamp_count(dims_cfg, MAX_DIMS);
      npts = clamp_count(points_cfg, MAX_POINTS);
      for (int j = 0; j < npts; j++) begin
         for (int d = 0; d < dims; d++) begin
            if (!loaded_mask[j][d]) load_coord(j, d, random_sample());
         end
      end
   endtask

   // A query may only touch coordinates that have been loaded.
   function automatic bit query_safe(int q);
      int dims;
      int npts;
      dims = clamp_count(dims_cfg, MAX_DIMS);
      npts = clamp_count(points_cfg, MAX_POINTS);
      for (int d = 0; d < dims; d++) begin
         if (!loaded_mask[q][d]) return 1'b0;
         for (int j = 0; j < npts; j++) begin
            if (!loaded_mask[j][d]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Reset registers: one neighbour, no exclusion, one coordinate, one point.
   task automatic test_reset_defaults();
      load_coord(0, 0, 16'h0000);
      query_point(0);
      load_coord(MAX_POINTS - 1, 0, 16'h7FFF);
      query_point(MAX_POINTS - 1);
      wait_idle();
   endtask

   // Hand-picked points: equal distances, extreme coordinates, unfilled slots,
   // full exclusion and a query point beyond the scanned range.
   task automatic test_directed_cases();
      configure(8, 0, 2, 5);
      load_coord(0, 0, 16'h0000);
      load_coord(0, 1, 16'h0000);
      load_coord(1, 0, 16'sd3);
      load_coord(1, 1, 16'sd4);
      load_coord(2, 0, -16'sd3);
      load_coord(2, 1, 16'sd4);
      load_coord(3, 0, 16'h7FFF);
      load_coord(3, 1, 16'h8000);
      load_coord(4, 0, 16'sd5);
      load_coord(4, 1, 16'sd0);
      query_point(0);
      query_point(3);
      // A full list of two: the later equal point replaces the last entry.
      configure(2, 0, 2, 5);
      query_point(0);
      // Every point lies inside the exclusion zone.
      configure(2, 1023, 2, 5);
      query_point(2);
      configure(8, 1, 2, 5);
      query_point(2);
      load_coord(MAX_POINTS - 1, 0, 16'h8000);
      load_coord(MAX_POINTS - 1, 1, 16'h7FFF);
      configure(8, 0, 2, 5);
      query_point(MAX_POINTS - 1);
      wait_idle();
   endtask

   // Largest coordinate count, register values that saturate at both ends,
   // and a wide exclusion zone around either end of the index range.
   task automatic test_largest_sizes();
      set_idling(0, 0);
      configure(15, 0, 31, 2);
      fill_active_set();
      query_point(0);
      query_point(1);
      configure(0, 0, 0, 0);
      set_idling(0, 30);
      query_point(0);
      query_point(MAX_POINTS - 1);
      configure(3, 700, 1, 5);
      query_point(MAX_POINTS - 1);
      query_point(0);
      wait_idle();
   endtask

   // The receiver holds off for a long stretch while queries keep coming.
   task automatic test_backpressure();
      set_idling(0, 0);
      configure(8, 0, 2, 6);
      fill_active_set();
      fork
         begin
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_on <= 1'b0;
         end
      join_none
      repeat (12) query_point($urandom_range(5));
      wait_idle();
   endtask

   // Random registers, well-formed loads of the scanned set, then mixed traffic.
   task automatic test_random_traffic();
      int k_raw;
      int radius;
      int dims_raw;
      int dims;
      int npts_raw;
      int npts;
      int q;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       set_idling(0, 0);
            1:       set_idling(70, 0);
            2:       set_idling(0, 70);
            default: set_idling(31, 31);
         endcase
         for (int c = 0; c < 2; c++) begin
            k_raw = $urandom_range(15);
            case ($urandom_range(3))
               0:       radius = 0;
               1:       radius = $urandom_range(3, 1);
               2:       radius = $urandom_range(1023);
               default: radius = $urandom_range(8);
            endcase
            dims_raw = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(6, 1);
            dims     = clamp_count(dims_raw, MAX_DIMS);
            if (dims >= 8) npts_raw = $urandom_range(2);
            else npts_raw = $urandom_range(8);
            npts = clamp_count(npts_raw, MAX_POINTS);
            configure(k_raw, radius, dims_raw, npts_raw);
            // Unused register indexes must leave the settings alone.
            if ($urandom_range(3) == 0)
               write_reg(CSR_POINTS + 3'd1 + CSR_INDEX_BITS'($urandom_range(3)), $urandom,
                         CSR_DATA_BITS);
            fill_active_set();
            repeat (3) begin
               if ($urandom_range(99) < 60) begin
                  q = ($urandom_range(4) == 0) ? $urandom_range(MAX_POINTS - 1)
                                               : $urandom_range(npts - 1);
                  if (!query_safe(q)) q = $urandom_range(npts - 1);
                  query_point(q);
               end else if ($urandom_range(1) == 1) begin
                  load_coord($urandom_range(npts - 1), $urandom_range(dims - 1),
                             random_sample());
               end else begin
                  load_coord($urandom_range(MAX_POINTS - 1), $urandom_range(MAX_DIMS - 1),
                             random_sample());
               end
            end
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_cases();
      test_largest_sizes();
      test_backpressure();
      test_random_traffic();
      set_idling(0, 0);
      wait_idle();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog for a block that hangs or loses results.
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
